@@ design/ssb_pkg.sv @@
// Shared types and constants of the sprite scale, tint and blend block.
`timescale 1ns / 1ps
`default_nettype none
package ssb_pkg;

  typedef struct packed {
    logic [8:0]  sprite_width;
    logic [8:0]  sprite_height;
    logic [8:0]  sprites_per_row;
    logic [12:0] sheet_width;
    logic [9:0]  target_width;
    logic [9:0]  target_height;
    logic [31:0] tint_color;
    logic [15:0] line_stride;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sprite_width:    9'd16,
    sprite_height:   9'd16,
    sprites_per_row: 9'd1,
    sheet_width:     13'd16,
    target_width:    10'd16,
    target_height:   10'd16,
    tint_color:      32'hFFFF_FFFF,
    line_stride:     16'd4096
  };

  localparam logic [2:0] REG_SPRITE_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SPRITE_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_SPRITES_PER_ROW = 3'd2;
  localparam logic [2:0] REG_SHEET_WIDTH     = 3'd3;
  localparam logic [2:0] REG_TARGET_WIDTH    = 3'd4;
  localparam logic [2:0] REG_TARGET_HEIGHT   = 3'd5;
  localparam logic [2:0] REG_TINT_COLOR      = 3'd6;
  localparam logic [2:0] REG_LINE_STRIDE     = 3'd7;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam int unsigned DIV_NUM_W = 19;
  localparam int unsigned DIV_DEN_W = 10;
  localparam int unsigned MID_DEPTH = 32;
  localparam int unsigned OUT_DEPTH = 4;

endpackage
`default_nettype wire

@@ design/ssb_fifo.sv @@
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps
`default_nettype none
module ssb_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [Width-1:0] data_o,
  output logic                  empty_o,
  output logic                  full_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("Queue written while full.");
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("Queue read while empty.");

endmodule
`default_nettype wire

@@ design/ssb_div.sv @@
// Pipelined restoring divider that resolves one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ssb_div #(
  parameter int unsigned NumW = 19,
  parameter int unsigned DenW = 10
) (
  input  wire logic            clk_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic      [NumW-1:0] quo_o,
  output logic      [DenW-1:0] rem_o
);
  logic [NumW-1:0] num_q [NumW];
  logic [DenW-1:0] rem_q [NumW];

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [NumW-1:0] pn;
    logic [DenW-1:0] pr;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;
    logic            ge;

    if (s == 0) begin : g_first
      assign pn = num_i;
      assign pr = '0;
    end else begin : g_next
      assign pn = num_q[s-1];
      assign pr = rem_q[s-1];
    end

    assign trial = {pr, pn[NumW-1]};
    assign ge    = (trial >= {1'b0, den_i});
    assign diff  = trial - {1'b0, den_i};

    always_ff @(posedge clk_i) begin
      num_q[s] <= {pn[NumW-2:0], ge};
      rem_q[s] <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
    end
  end

  assign quo_o = num_q[NumW-1];
  assign rem_o = rem_q[NumW-1];

endmodule
`default_nettype wire

@@ design/ssb_front.sv @@
// Front part: accepts transactions, divides and computes sheet and frame addresses.
`timescale 1ns / 1ps
`default_nettype none
module ssb_front #(
  parameter int unsigned AddrW = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssb_pkg::cfg_t     cfg_i,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              kind_i,
  input  wire logic [15:0]       load_address_i,
  input  wire logic [31:0]       load_texel_i,
  input  wire logic [15:0]       sprite_index_i,
  input  wire logic [9:0]        pos_x_i,
  input  wire logic [9:0]        pos_y_i,
  input  wire logic [11:0]       origin_x_i,
  input  wire logic [11:0]       origin_y_i,
  input  wire logic [31:0]       dest_pixel_i,
  input  wire logic              mid_pop_i,
  output logic                   mid_push_o,
  output logic                   mid_kind_o,
  output logic      [AddrW-1:0]  mid_addr_o,
  output logic      [31:0]       mid_data_o,
  output logic      [31:0]       mid_daddr_o
);
  import ssb_pkg::*;

  localparam int unsigned N    = DIV_NUM_W;
  localparam int unsigned OccW = $clog2(MID_DEPTH + 1);
  localparam int unsigned VwW  = AddrW + 13;

  logic [OccW-1:0] occ_q, occ_d;
  logic            accept;

  logic             f0_valid_q, f0_kind_q;
  logic [AddrW-1:0] f0_addr_q;
  logic [31:0]      f0_data_q;
  logic [12:0]      f0_xsum_q, f0_ysum_q;
  logic [N-1:0]     f0_index_q, f0_prodx_q, f0_prody_q;

  logic             sd_valid_q [N];
  logic             sd_kind_q  [N];
  logic [AddrW-1:0] sd_addr_q  [N];
  logic [31:0]      sd_data_q  [N];
  logic [12:0]      sd_xsum_q  [N];
  logic [12:0]      sd_ysum_q  [N];

  logic [DIV_DEN_W-1:0] per_row;
  logic [N-1:0]         quo_idx, quo_x, quo_y;
  logic [DIV_DEN_W-1:0] rem_idx;
  logic [N-1:0]         sx, sy;
  logic [20:0]          u_full;
  logic [28:0]          v_full;
  logic [31:0]          daddr;

  logic             e1_valid_q, e1_kind_q;
  logic [AddrW-1:0] e1_addr_q, e1_u_q, e1_v_q;
  logic [31:0]      e1_data_q, e1_daddr_q;
  logic [VwW-1:0]   vw;
  logic [AddrW-1:0] taddr;

  assign full_o = (occ_q == OccW'(MID_DEPTH));
  assign accept = push_i && !full_o;

  always_comb begin
    occ_d = occ_q;
    if (accept && !mid_pop_i) begin
      occ_d = occ_q + 1'b1;
    end else if (mid_pop_i && !accept) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      f0_valid_q <= 1'b0;
      e1_valid_q <= 1'b0;
      mid_push_o <= 1'b0;
      for (int i = 0; i < N; i++) begin
        sd_valid_q[i] <= 1'b0;
      end
    end else begin
      occ_q         <= occ_d;
      f0_valid_q    <= accept;
      sd_valid_q[0] <= f0_valid_q;
      for (int i = 1; i < N; i++) begin
        sd_valid_q[i] <= sd_valid_q[i-1];
      end
      e1_valid_q <= sd_valid_q[N-1];
      mid_push_o <= e1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f0_kind_q  <= kind_i;
    f0_addr_q  <= AddrW'(load_address_i);
    f0_data_q  <= (kind_i == KIND_DRAW) ? dest_pixel_i : load_texel_i;
    f0_xsum_q  <= 13'(origin_x_i) + 13'(pos_x_i);
    f0_ysum_q  <= 13'(origin_y_i) + 13'(pos_y_i);
    f0_index_q <= N'(sprite_index_i);
    f0_prodx_q <= N'(pos_x_i) * N'(cfg_i.sprite_width);
    f0_prody_q <= N'(pos_y_i) * N'(cfg_i.sprite_height);

    sd_kind_q[0] <= f0_kind_q;
    sd_addr_q[0] <= f0_addr_q;
    sd_data_q[0] <= f0_data_q;
    sd_xsum_q[0] <= f0_xsum_q;
    sd_ysum_q[0] <= f0_ysum_q;
    for (int i = 1; i < N; i++) begin
      sd_kind_q[i] <= sd_kind_q[i-1];
      sd_addr_q[i] <= sd_addr_q[i-1];
      sd_data_q[i] <= sd_data_q[i-1];
      sd_xsum_q[i] <= sd_xsum_q[i-1];
      sd_ysum_q[i] <= sd_ysum_q[i-1];
    end
  end

  assign per_row = (cfg_i.sprites_per_row == '0) ? DIV_DEN_W'(1)
                                                 : DIV_DEN_W'(cfg_i.sprites_per_row);

  ssb_div #(.NumW(N), .DenW(DIV_DEN_W)) u_div_idx (
    .clk_i (clk_i),
    .num_i (f0_index_q),
    .den_i (per_row),
    .quo_o (quo_idx),
    .rem_o (rem_idx)
  );

  ssb_div #(.NumW(N), .DenW(DIV_DEN_W)) u_div_x (
    .clk_i (clk_i),
    .num_i (f0_prodx_q),
    .den_i (cfg_i.target_width),
    .quo_o (quo_x),
    .rem_o ()
  );

  ssb_div #(.NumW(N), .DenW(DIV_DEN_W)) u_div_y (
    .clk_i (clk_i),
    .num_i (f0_prody_q),
    .den_i (cfg_i.target_height),
    .quo_o (quo_y),
    .rem_o ()
  );

  assign sx     = (cfg_i.target_width == '0) ? '0 : quo_x;
  assign sy     = (cfg_i.target_height == '0) ? '0 : quo_y;
  assign u_full = 21'(rem_idx[8:0]) * 21'(cfg_i.sprite_width) + 21'(sx);
  assign v_full = 29'(quo_idx[15:0]) * 29'(cfg_i.sprite_height) + 29'(sy);
  assign daddr  = 32'(sd_ysum_q[N-1]) * 32'(cfg_i.line_stride)
                + {17'd0, sd_xsum_q[N-1], 2'b00};

  always_ff @(posedge clk_i) begin
    e1_kind_q  <= sd_kind_q[N-1];
    e1_addr_q  <= sd_addr_q[N-1];
    e1_data_q  <= sd_data_q[N-1];
    e1_u_q     <= u_full[AddrW-1:0];
    e1_v_q     <= v_full[AddrW-1:0];
    e1_daddr_q <= daddr;
  end

  assign vw    = VwW'(e1_v_q) * VwW'(cfg_i.sheet_width);
  assign taddr = e1_u_q + vw[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    mid_kind_o  <= e1_kind_q;
    mid_addr_o  <= (e1_kind_q == KIND_DRAW) ? taddr : e1_addr_q;
    mid_data_o  <= e1_data_q;
    mid_daddr_o <= e1_daddr_q;
  end

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(MID_DEPTH)) else $error("Front occupancy exceeds the queue depth.");

endmodule
`default_nettype wire

@@ design/ssb_back.sv @@
// Back part: sheet memory access, tint and alpha blend.
`timescale 1ns / 1ps
`default_nettype none
module ssb_back #(
  parameter int unsigned AddrW = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      tint_i,
  input  wire logic             mid_empty_i,
  input  wire logic             mid_kind_i,
  input  wire logic [AddrW-1:0] mid_addr_i,
  input  wire logic [31:0]      mid_data_i,
  input  wire logic [31:0]      mid_daddr_i,
  output logic                  mid_pop_o,
  input  wire logic             out_pop_i,
  output logic                  out_push_o,
  output logic      [31:0]      out_daddr_o,
  output logic      [31:0]      out_pixel_o
);
  import ssb_pkg::*;

  localparam int unsigned OccW = $clog2(OUT_DEPTH + 1);

  logic [31:0]     mem_q [2**AddrW];
  logic [OccW-1:0] occ_q, occ_d;
  logic            take_draw;

  logic        b1_valid_q;
  logic [31:0] b1_texel_q, b1_dst_q, b1_daddr_q;

  logic [31:0] tinted;
  logic [7:0]  alpha;
  logic [15:0] ps [3];
  logic [15:0] pd [3];

  logic        b2_valid_q, b2_opaque_q;
  logic [31:0] b2_texel_q, b2_daddr_q;
  logic [15:0] b2_ps_q [3];
  logic [15:0] b2_pd_q [3];
  logic [16:0] sum [3];

  assign mid_pop_o = !mid_empty_i && ((mid_kind_i == KIND_LOAD) || (occ_q != OccW'(OUT_DEPTH)));
  assign take_draw = mid_pop_o && (mid_kind_i == KIND_DRAW);

  always_comb begin
    occ_d = occ_q;
    if (take_draw && !out_pop_i) begin
      occ_d = occ_q + 1'b1;
    end else if (out_pop_i && !take_draw) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      occ_q      <= occ_d;
      b1_valid_q <= take_draw;
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o && (mid_kind_i == KIND_LOAD)) begin
      mem_q[mid_addr_i] <= mid_data_i;
    end
    b1_texel_q <= mem_q[mid_addr_i];
    b1_dst_q   <= mid_data_i;
    b1_daddr_q <= mid_daddr_i;
  end

  always_comb begin
    tinted = b1_texel_q;
    for (int c = 0; c < 3; c++) begin
      if (tint_i[8*c +: 8] != 8'hFF) begin
        tinted[8*c +: 8] = tint_i[8*c +: 8];
      end
    end
    alpha = tinted[31:24];
    for (int c = 0; c < 3; c++) begin
      ps[c] = 16'(tinted[8*c +: 8]) * 16'(alpha);
      pd[c] = 16'(b1_dst_q[8*c +: 8]) * 16'(8'hFF - alpha);
    end
  end

  always_ff @(posedge clk_i) begin
    b2_opaque_q <= (alpha == 8'hFF);
    b2_texel_q  <= tinted;
    b2_daddr_q  <= b1_daddr_q;
    for (int c = 0; c < 3; c++) begin
      b2_ps_q[c] <= ps[c];
      b2_pd_q[c] <= pd[c];
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = 17'(b2_ps_q[c]) + 17'(b2_pd_q[c]);
    end
  end

  assign out_push_o  = b2_valid_q;
  assign out_daddr_o = b2_daddr_q;
  assign out_pixel_o = b2_opaque_q ? b2_texel_q
                                   : {8'hFF, sum[2][15:8], sum[1][15:8], sum[0][15:8]};

  a_credit_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(OUT_DEPTH)) else $error("Result credits exceed the queue depth.");

endmodule
`default_nettype wire

@@ design/sprite_scale_tint_blend_core.sv @@
// Top level of the sprite scale, tint and blend block with its register file.
// The block takes one transaction per clock while full is low, and returns one result
// per clock for a stream of draw transactions while the result queue is popped. A draw
// result passes one input stage, 19 stages of the pipelined dividers that split the
// sprite index and scale both coordinates, two address stages, the queue between front
// and back, the sheet memory read, one blend stage and the write into the result queue.
// A load transaction writes its texel into the sheet memory in the same order as draws
// and returns nothing. The sheet memory is not cleared at reset; draw only texels that
// were loaded.
`timescale 1ns / 1ps
`default_nettype none
module sprite_scale_tint_blend_core #(
  parameter int unsigned SHEET_ADDR_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind_i,
  input  wire logic [15:0] load_address_i,
  input  wire logic [31:0] load_texel_i,
  input  wire logic [15:0] sprite_index_i,
  input  wire logic [9:0]  pos_x_i,
  input  wire logic [9:0]  pos_y_i,
  input  wire logic [11:0] origin_x_i,
  input  wire logic [11:0] origin_y_i,
  input  wire logic [31:0] dest_pixel_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      dest_address_o,
  output logic [31:0]      pixel_value_o
);
  import ssb_pkg::*;

  localparam int unsigned AddrW = SHEET_ADDR_BITS;
  localparam int unsigned MidW  = 1 + AddrW + 64;

  cfg_t cfg_q, cfg_d;
  logic cfg_we;

  logic             mid_push, mid_pop, mid_empty, mid_full;
  logic             f_kind, b_kind;
  logic [AddrW-1:0] f_addr, b_addr;
  logic [31:0]      f_data, f_daddr, b_data, b_daddr;
  logic [MidW-1:0]  mid_wdata, mid_rdata;

  logic        out_push;
  logic [31:0] out_daddr, out_pixel;
  logic [63:0] out_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (paddr[4:2])
        REG_SPRITE_WIDTH:    cfg_d.sprite_width    = pwdata[8:0];
        REG_SPRITE_HEIGHT:   cfg_d.sprite_height   = pwdata[8:0];
        REG_SPRITES_PER_ROW: cfg_d.sprites_per_row = pwdata[8:0];
        REG_SHEET_WIDTH:     cfg_d.sheet_width     = pwdata[12:0];
        REG_TARGET_WIDTH:    cfg_d.target_width    = pwdata[9:0];
        REG_TARGET_HEIGHT:   cfg_d.target_height   = pwdata[9:0];
        REG_TINT_COLOR:      cfg_d.tint_color      = pwdata;
        REG_LINE_STRIDE:     cfg_d.line_stride     = pwdata[15:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SPRITE_WIDTH:    prdata = 32'(cfg_q.sprite_width);
      REG_SPRITE_HEIGHT:   prdata = 32'(cfg_q.sprite_height);
      REG_SPRITES_PER_ROW: prdata = 32'(cfg_q.sprites_per_row);
      REG_SHEET_WIDTH:     prdata = 32'(cfg_q.sheet_width);
      REG_TARGET_WIDTH:    prdata = 32'(cfg_q.target_width);
      REG_TARGET_HEIGHT:   prdata = 32'(cfg_q.target_height);
      REG_TINT_COLOR:      prdata = cfg_q.tint_color;
      REG_LINE_STRIDE:     prdata = 32'(cfg_q.line_stride);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ssb_front #(.AddrW(AddrW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .push_i         (push),
    .full_o         (full),
    .kind_i         (kind_i),
    .load_address_i (load_address_i),
    .load_texel_i   (load_texel_i),
    .sprite_index_i (sprite_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .dest_pixel_i   (dest_pixel_i),
    .mid_pop_i      (mid_pop),
    .mid_push_o     (mid_push),
    .mid_kind_o     (f_kind),
    .mid_addr_o     (f_addr),
    .mid_data_o     (f_data),
    .mid_daddr_o    (f_daddr)
  );

  assign mid_wdata = {f_kind, f_addr, f_data, f_daddr};
  assign {b_kind, b_addr, b_data, b_daddr} = mid_rdata;

  ssb_fifo #(.Width(MidW), .Depth(MID_DEPTH)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  ssb_back #(.AddrW(AddrW)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tint_i      (cfg_q.tint_color),
    .mid_empty_i (mid_empty),
    .mid_kind_i  (b_kind),
    .mid_addr_i  (b_addr),
    .mid_data_i  (b_data),
    .mid_daddr_i (b_daddr),
    .mid_pop_o   (mid_pop),
    .out_pop_i   (pop && !empty),
    .out_push_o  (out_push),
    .out_daddr_o (out_daddr),
    .out_pixel_o (out_pixel)
  );

  ssb_fifo #(.Width(64), .Depth(OUT_DEPTH)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({out_daddr, out_pixel}),
    .pop_i   (pop && !empty),
    .data_o  (out_rdata),
    .empty_o (empty),
    .full_o  ()
  );

  assign dest_address_o = out_rdata[63:32];
  assign pixel_value_o  = out_rdata[31:0];

  a_mid_full_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_full |-> full) else $error("Middle queue full while input still open.");

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the sprite scale, tint and blend block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ssb_pkg::*;

  class blit_scoreboard;
    logic [31:0] sheet_mem [int];
    cfg_t        cfg;
    logic [63:0] pending_q[$];
    int          mismatches;
    int          results_seen;

    function void note_input(logic k, logic [15:0] la, logic [31:0] lt,
                             logic [15:0] idx, logic [9:0] px, logic [9:0] py,
                             logic [11:0] ox, logic [11:0] oy, logic [31:0] dst);
      longint unsigned per_row, col, row, u, v, su, sv, da;
      logic [15:0] taddr;
      logic [31:0] tex, res;
      logic [7:0]  tb, a, s, d;
      if (k == KIND_LOAD) begin
        sheet_mem[la] = lt;
        return;
      end
      per_row = (cfg.sprites_per_row == 0) ? 1 : cfg.sprites_per_row;
      col = idx % per_row;
      row = idx / per_row;
      su = (cfg.target_width == 0) ? 0 : (px * cfg.sprite_width) / cfg.target_width;
      sv = (cfg.target_height == 0) ? 0 : (py * cfg.sprite_height) / cfg.target_height;
      u = col * cfg.sprite_width + su;
      v = row * cfg.sprite_height + sv;
      taddr = 16'(u + v * cfg.sheet_width);
      tex = sheet_mem.exists(taddr) ? sheet_mem[taddr] : 32'h0;
      for (int b = 0; b < 3; b++) begin
        tb = cfg.tint_color[8*b +: 8];
        if (tb != 8'hFF) tex[8*b +: 8] = tb;
      end
      a = tex[31:24];
      if (a == 8'hFF) res = tex;
      else begin
        res = 32'hFF00_0000;
        for (int b = 0; b < 3; b++) begin
          s = tex[8*b +: 8];
          d = dst[8*b +: 8];
          res[8*b +: 8] = 8'((32'(s) * a + 32'(d) * (255 - a)) >> 8);
        end
      end
      da = (longint'(oy) + py) * cfg.line_stride + ((longint'(ox) + px) << 2);
      pending_q.push_back({da[31:0], res});
    endfunction

    function void check_result(logic [31:0] addr, logic [31:0] pix);
      logic [63:0] exp_v;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result addr=%h pix=%h", addr, pix);
        return;
      end
      exp_v = pending_q.pop_front();
      if (exp_v[63:32] !== addr || exp_v[31:0] !== pix) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: addr exp %h got %h, pixel exp %h got %h",
                   exp_v[63:32], addr, exp_v[31:0], pix);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready, push, full, empty, pop;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic kind_i;
  logic [15:0] load_address_i, sprite_index_i;
  logic [31:0] load_texel_i, dest_pixel_i, dest_address_o, pixel_value_o;
  logic [9:0]  pos_x_i, pos_y_i;
  logic [11:0] origin_x_i, origin_y_i;

  sprite_scale_tint_blend_core u_top (.*);

  blit_scoreboard sb;
  longint cycles;
  bit quiet_push, quiet_pop;
  logic [15:0] loaded_q[$];

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Timeout");
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && pop && !empty) sb.check_result(dest_address_o, pixel_value_o);

  always @(negedge clk_i)
    if (!rst_ni) pop <= 0;
    else pop <= quiet_pop ? 1'b1 : ($urandom_range(99) >= 21);

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SPRITE_WIDTH:    sb.cfg.sprite_width = val[8:0];
      REG_SPRITE_HEIGHT:   sb.cfg.sprite_height = val[8:0];
      REG_SPRITES_PER_ROW: sb.cfg.sprites_per_row = val[8:0];
      REG_SHEET_WIDTH:     sb.cfg.sheet_width = val[12:0];
      REG_TARGET_WIDTH:    sb.cfg.target_width = val[9:0];
      REG_TARGET_HEIGHT:   sb.cfg.target_height = val[9:0];
      REG_TINT_COLOR:      sb.cfg.tint_color = val;
      default:             sb.cfg.line_stride = val[15:0];
    endcase
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_item(logic k, logic [15:0] la, logic [31:0] lt, logic [15:0] idx,
                           logic [9:0] px, logic [9:0] py, logic [11:0] ox,
                           logic [11:0] oy, logic [31:0] dst);
    while (!quiet_push && $urandom_range(99) < 21) begin
      push <= 0;
      @(negedge clk_i);
    end
    push <= 1; kind_i <= k; load_address_i <= la; load_texel_i <= lt;
    sprite_index_i <= idx; pos_x_i <= px; pos_y_i <= py; origin_x_i <= ox;
    origin_y_i <= oy; dest_pixel_i <= dst;
    do @(posedge clk_i); while (full);
    sb.note_input(k, la, lt, idx, px, py, ox, oy, dst);
    if (k == KIND_LOAD) loaded_q.push_back(la);
    @(negedge clk_i);
  endtask

  task automatic load_texel(logic [15:0] la, logic [31:0] lt);
    send_item(KIND_LOAD, la, lt, 16'($urandom), 10'($urandom), 10'($urandom),
              12'($urandom), 12'($urandom), $urandom);
  endtask

  // Draw with the tile solved so that the texel read was loaded.
  task automatic draw_loaded(logic [9:0] px, logic [9:0] py, logic [11:0] ox,
                             logic [11:0] oy, logic [31:0] dst);
    longint unsigned pr, su, sv, base, want;
    logic [15:0] target, idx;
    int tries;
    pr = (sb.cfg.sprites_per_row == 0) ? 1 : sb.cfg.sprites_per_row;
    su = (sb.cfg.target_width == 0) ? 0 : (px * sb.cfg.sprite_width) / sb.cfg.target_width;
    sv = (sb.cfg.target_height == 0) ? 0 : (py * sb.cfg.sprite_height) / sb.cfg.target_height;
    target = loaded_q[$urandom_range(loaded_q.size() - 1)];
    idx = 16'($urandom);
    for (tries = 0; tries < 64; tries++) begin
      base = (idx % pr) * sb.cfg.sprite_width + su +
             ((idx / pr) * sb.cfg.sprite_height + sv) * sb.cfg.sheet_width;
      want = base & 64'hFFFF;
      if (want == target) break;
      idx = 16'($urandom);
    end
    if (want != target) load_texel(16'(want), $urandom);
    send_item(KIND_DRAW, 16'($urandom), $urandom, idx, px, py, ox, oy, dst);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      quiet_push = (i > n / 2) && (i < n / 2 + 40);
      quiet_pop = quiet_push;
      if ($urandom_range(3) == 0) load_texel(16'($urandom), $urandom);
      else draw_loaded(10'($urandom_range(1022)), 10'($urandom_range(1022)),
                       12'($urandom), 12'($urandom), $urandom);
    end
    quiet_push = 0; quiet_pop = 0;
    push <= 0;
    drain();
  endtask

  initial begin
    sb = new();
    sb.cfg = CFG_RESET;
    rst_ni = 0; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    push = 0; kind_i = 0; load_address_i = 0; load_texel_i = 0; sprite_index_i = 0;
    pos_x_i = 0; pos_y_i = 0; origin_x_i = 0; origin_y_i = 0; dest_pixel_i = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    load_texel(16'h0000, 32'hFF12_3456);
    load_texel(16'hFFFF, 32'h0000_0000);
    load_texel(16'h0011, 32'h80FF_00AA);
    load_texel(16'h0022, 32'hFE01_02FF);
    load_texel(16'h42DE, 32'h7F80_4020);
    send_item(KIND_DRAW, 16'd0, 32'd0, 16'd0, 10'd0, 10'd0, 12'd0, 12'd0, 32'hFFFF_FFFF);
    send_item(KIND_DRAW, 16'd0, 32'd0, 16'd0, 10'd1, 10'd1, 12'hFFF, 12'hFFF, 32'h0);
    send_item(KIND_DRAW, 16'd0, 32'd0, 16'd0, 10'd2, 10'd2, 12'h123, 12'h456,
              32'h5566_7788);
    send_item(KIND_DRAW, 16'd0, 32'd0, 16'd4095, 10'd1022, 10'd1022, 12'hFFF, 12'hFFF,
              32'hFFFF_FFFF);
    draw_loaded(10'd1022, 10'd0, 12'd0, 12'd0, 32'h0);
    draw_loaded(10'd0, 10'd1022, 12'hFFF, 12'd0, 32'hFFFF_FFFF);
    push <= 0;
    drain();

    write_reg(REG_TINT_COLOR, 32'h0000_7FFF);
    write_reg(REG_SPRITES_PER_ROW, 32'd0);
    write_reg(REG_TARGET_WIDTH, 32'd0);
    write_reg(REG_TARGET_HEIGHT, 32'd0);
    write_reg(REG_LINE_STRIDE, 32'hFFFF);
    draw_loaded(10'd5, 10'd7, 12'hFFF, 12'hFFF, 32'hA5A5_A5A5);
    draw_loaded(10'd1022, 10'd1022, 12'hFFF, 12'hFFF, 32'h0);
    push <= 0;
    drain();

    write_reg(REG_SPRITE_WIDTH, 32'd256);
    write_reg(REG_SPRITE_HEIGHT, 32'd256);
    write_reg(REG_SPRITES_PER_ROW, 32'd256);
    write_reg(REG_SHEET_WIDTH, 32'd4096);
    write_reg(REG_TARGET_WIDTH, 32'd1023);
    write_reg(REG_TARGET_HEIGHT, 32'd1023);
    write_reg(REG_TINT_COLOR, 32'hFFFF_FFFF);
    write_reg(REG_LINE_STRIDE, 32'd0);
    random_phase(145);

    write_reg(REG_SPRITE_WIDTH, 32'd1);
    write_reg(REG_SPRITE_HEIGHT, 32'd1);
    write_reg(REG_SPRITES_PER_ROW, 32'd1);
    write_reg(REG_SHEET_WIDTH, 32'd1);
    write_reg(REG_TARGET_WIDTH, 32'd1);
    write_reg(REG_TARGET_HEIGHT, 32'd1);
    write_reg(REG_TINT_COLOR, 32'h12FF_34FF);
    write_reg(REG_LINE_STRIDE, 32'd65535);
    random_phase(145);

    write_reg(REG_SPRITE_WIDTH, 32'd24);
    write_reg(REG_SPRITE_HEIGHT, 32'd9);
    write_reg(REG_SPRITES_PER_ROW, 32'd7);
    write_reg(REG_SHEET_WIDTH, 32'd168);
    write_reg(REG_TARGET_WIDTH, 32'd50);
    write_reg(REG_TARGET_HEIGHT, 32'd33);
    write_reg(REG_TINT_COLOR, 32'hFF80_FFFF);
    write_reg(REG_LINE_STRIDE, 32'd2560);
    random_phase(145);

    $display("Covered loads, draws and eight register settings, including the extremes;");
    $display("%0d results were checked.", sb.results_seen);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
